@@ design/wmsc_pkg.sv @@
// shared types, codes and tables for the wasm module structure checker
`timescale 1ns / 1ps
`default_nettype none

package wmsc_pkg;

	typedef enum logic [2:0] {
		OP_SECTION    = 3'd0,
		OP_LOCALS     = 3'd1,
		OP_INSTR      = 3'd2,
		OP_FUNC_END   = 3'd3,
		OP_MODULE_END = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_UNKNOWN_ID  = 3'd1,
		ST_ORDER       = 3'd2,
		ST_FUNC_CODE   = 3'd3,
		ST_DATACOUNT   = 3'd4,
		ST_LOCALS      = 3'd5,
		ST_DC_REQUIRED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		SF_NONE    = 2'd0,
		SF_UNKNOWN = 2'd1,
		SF_ORDER   = 2'd2
	} sect_fault_t;

	typedef enum logic [1:0] {
		BF_NONE   = 2'd0,
		BF_LOCALS = 2'd1,
		BF_DATA   = 2'd2
	} body_fault_t;

	localparam logic [7:0] ID_CUSTOM     = 8'd0;
	localparam logic [7:0] ID_FUNCTION   = 8'd3;
	localparam logic [7:0] ID_CODE       = 8'd10;
	localparam logic [7:0] ID_DATA       = 8'd11;
	localparam logic [7:0] ID_DATA_COUNT = 8'd12;
	localparam logic [7:0] ID_LAST_KNOWN = 8'd13;

	localparam logic [7:0]  PREFIX_MISC         = 8'hFC;
	localparam logic [7:0]  PREFIX_GC           = 8'hFB;
	localparam logic [31:0] SUB_MEMORY_INIT     = 32'd8;
	localparam logic [31:0] SUB_DATA_DROP       = 32'd9;
	localparam logic [31:0] SUB_ARRAY_NEW_DATA  = 32'd9;
	localparam logic [31:0] SUB_ARRAY_INIT_DATA = 32'd18;

	localparam logic [32:0] LOCALS_SAT = 33'h1_0000_0000;

	typedef struct packed {
		sect_fault_t fault;
		logic        func_code_mismatch;
		logic        data_count_mismatch;
		logic        has_data_count;
	} sect_stat_t;

	function automatic logic [3:0] rank_of_id(input logic [7:0] id);
		logic [3:0] r;
		case (id)
			8'd1:    r = 4'd0;
			8'd2:    r = 4'd1;
			8'd3:    r = 4'd2;
			8'd4:    r = 4'd3;
			8'd5:    r = 4'd4;
			8'd6:    r = 4'd6;
			8'd7:    r = 4'd7;
			8'd8:    r = 4'd8;
			8'd9:    r = 4'd9;
			8'd10:   r = 4'd11;
			8'd11:   r = 4'd12;
			8'd12:   r = 4'd10;
			8'd13:   r = 4'd5;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/wmsc_sect.sv @@
// section order tracking and section count comparison
`timescale 1ns / 1ps
`default_nettype none

module wmsc_sect (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic [2:0]           op,
	input  wire logic [7:0]           section_id,
	input  wire logic [31:0]          item_count,
	output wmsc_pkg::sect_stat_t      stat
);
	import wmsc_pkg::*;

	logic [3:0]  last_rank_q;
	logic        rank_seen_q;
	logic [31:0] func_total_q;
	logic [31:0] code_total_q;
	logic [31:0] data_total_q;
	logic [31:0] data_count_q;
	logic        has_dc_q;
	sect_fault_t fault_q;
	logic [3:0]  rank;

	assign rank = rank_of_id(section_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rank_q  <= '0;
			rank_seen_q  <= 1'b0;
			func_total_q <= '0;
			code_total_q <= '0;
			data_total_q <= '0;
			data_count_q <= '0;
			has_dc_q     <= 1'b0;
			fault_q      <= SF_NONE;
		end else if (adv) begin
			if (op == OP_MODULE_END) begin
				last_rank_q  <= '0;
				rank_seen_q  <= 1'b0;
				func_total_q <= '0;
				code_total_q <= '0;
				data_total_q <= '0;
				data_count_q <= '0;
				has_dc_q     <= 1'b0;
				fault_q      <= SF_NONE;
			end else if (op == OP_SECTION && fault_q == SF_NONE && section_id != ID_CUSTOM) begin
				if (section_id > ID_LAST_KNOWN) begin
					fault_q <= SF_UNKNOWN;
				end else if (rank_seen_q && rank <= last_rank_q) begin
					fault_q <= SF_ORDER;
				end else begin
					last_rank_q <= rank;
					rank_seen_q <= 1'b1;
					if (section_id == ID_FUNCTION) begin
						func_total_q <= item_count;
					end
					if (section_id == ID_CODE) begin
						code_total_q <= item_count;
					end
					if (section_id == ID_DATA) begin
						data_total_q <= item_count;
					end
					if (section_id == ID_DATA_COUNT) begin
						data_count_q <= item_count;
						has_dc_q     <= 1'b1;
					end
				end
			end
		end
	end

	assign stat.fault               = fault_q;
	assign stat.func_code_mismatch  = func_total_q != code_total_q;
	assign stat.data_count_mismatch = has_dc_q && (data_count_q != data_total_q);
	assign stat.has_data_count      = has_dc_q;

endmodule

`default_nettype wire

@@ design/wmsc_body.sv @@
// per function body checks: locals sum and data segment use
`timescale 1ns / 1ps
`default_nettype none

module wmsc_body (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic [2:0]           op,
	input  wire logic [31:0]          item_count,
	input  wire logic [7:0]           opcode,
	input  wire logic [31:0]          sub_opcode,
	input  wire logic                 has_data_count,
	output wmsc_pkg::body_fault_t     fault
);
	import wmsc_pkg::*;

	logic [32:0] locals_sum_q;
	logic        uses_data_q;
	body_fault_t fault_q;
	logic [33:0] sum_next;
	logic        data_instr;

	assign sum_next = {1'b0, locals_sum_q} + {2'b00, item_count};

	assign data_instr = (opcode == PREFIX_MISC &&
			(sub_opcode == SUB_MEMORY_INIT || sub_opcode == SUB_DATA_DROP)) ||
		(opcode == PREFIX_GC &&
			(sub_opcode == SUB_ARRAY_NEW_DATA || sub_opcode == SUB_ARRAY_INIT_DATA));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locals_sum_q <= '0;
			uses_data_q  <= 1'b0;
			fault_q      <= BF_NONE;
		end else if (adv) begin
			case (op)
				OP_LOCALS: begin
					if (sum_next > {1'b0, LOCALS_SAT}) begin
						locals_sum_q <= LOCALS_SAT;
					end else begin
						locals_sum_q <= sum_next[32:0];
					end
				end
				OP_INSTR: begin
					if (data_instr) begin
						uses_data_q <= 1'b1;
					end
				end
				OP_FUNC_END: begin
					if (fault_q == BF_NONE) begin
						if (locals_sum_q[32]) begin
							fault_q <= BF_LOCALS;
						end else if (uses_data_q && !has_data_count) begin
							fault_q <= BF_DATA;
						end
					end
					locals_sum_q <= '0;
					uses_data_q  <= 1'b0;
				end
				OP_MODULE_END: begin
					locals_sum_q <= '0;
					uses_data_q  <= 1'b0;
					fault_q      <= BF_NONE;
				end
				default: begin
				end
			endcase
		end
	end

	assign fault = fault_q;

endmodule

`default_nettype wire

@@ design/wasm_module_structure_checker.sv @@
// top level of the wasm module structure checker
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per cycle unless stalled and returns exactly one result per item: an input
// register holds the item, then the section and body trackers update their state from it
// while the result register is loaded. Only the module end item carries a verdict
// (done_res high, accepted and status); every other result is all zero. Faults are sticky
// across the module and all tracker state returns to reset after module end. The input
// stalls only while a held result is itself stalled.

module wasm_module_structure_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [7:0]  section_id,
	input  wire logic [31:0] item_count,
	input  wire logic [7:0]  opcode,
	input  wire logic [31:0] sub_opcode,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             done_res,
	output logic             accepted,
	output logic [2:0]       status
);
	import wmsc_pkg::*;

	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [7:0]  section_id_s1;
	logic [31:0] item_count_s1;
	logic [7:0]  opcode_s1;
	logic [31:0] sub_opcode_s1;
	logic        stall_s1;
	logic        adv;
	sect_stat_t  sect_stat;
	body_fault_t body_fault;
	status_t     verdict;
	logic        out_valid_q;
	logic        done_q;
	logic        accepted_q;
	logic [2:0]  status_q;

	assign stall_s1 = out_valid_q && out_stall;
	assign adv      = valid_s1 && !stall_s1;
	assign in_stall = valid_s1 && stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1         <= op;
			section_id_s1 <= section_id;
			item_count_s1 <= item_count;
			opcode_s1     <= opcode;
			sub_opcode_s1 <= sub_opcode;
		end
	end

	wmsc_sect u_sect (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.op         (op_s1),
		.section_id (section_id_s1),
		.item_count (item_count_s1),
		.stat       (sect_stat)
	);

	wmsc_body u_body (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.op             (op_s1),
		.item_count     (item_count_s1),
		.opcode         (opcode_s1),
		.sub_opcode     (sub_opcode_s1),
		.has_data_count (sect_stat.has_data_count),
		.fault          (body_fault)
	);

	always_comb begin
		if (sect_stat.fault == SF_UNKNOWN) begin
			verdict = ST_UNKNOWN_ID;
		end else if (sect_stat.fault == SF_ORDER) begin
			verdict = ST_ORDER;
		end else if (sect_stat.func_code_mismatch) begin
			verdict = ST_FUNC_CODE;
		end else if (sect_stat.data_count_mismatch) begin
			verdict = ST_DATACOUNT;
		end else if (body_fault == BF_LOCALS) begin
			verdict = ST_LOCALS;
		end else if (body_fault == BF_DATA) begin
			verdict = ST_DC_REQUIRED;
		end else begin
			verdict = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (op_s1 == OP_MODULE_END) begin
				done_q     <= 1'b1;
				accepted_q <= verdict == ST_OK;
				status_q   <= verdict;
			end else begin
				done_q     <= 1'b0;
				accepted_q <= 1'b0;
				status_q   <= ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign done_res  = done_q;
	assign accepted  = accepted_q;
	assign status    = status_q;

endmodule

`default_nettype wire

@@ design/wmsc_chk.sv @@
// port level assertions for the wasm module structure checker, with bind
`timescale 1ns / 1ps
`default_nettype none

module wmsc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        done_res,
	input wire logic        accepted,
	input wire logic [2:0]  status
);
	import wmsc_pkg::*;

	// only the module end transaction carries a verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> !accepted && status == ST_OK)
		else $error("verdict on a non module end transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> accepted == (status == ST_OK))
		else $error("accepted disagrees with status");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 3'd7)
		else $error("status code out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(done_res) && $stable(status)
			&& $stable(accepted))
		else $error("stalled result changed");

	// input held off only behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

endmodule

bind wasm_module_structure_checker wmsc_chk u_wmsc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.done_res  (done_res),
	.accepted  (accepted),
	.status    (status)
);

`default_nettype wire
